[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Each macro takes a label, the clock, the reset, the trigger, the check and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/ipv4_echo_pkg.sv]
`timescale 1ns / 1ps
package ipv4_echo_pkg;

   // Bytes held back before a reply byte leaves, plus the newest byte
   localparam int LAG = 8;
   localparam int WIN = LAG + 1;

   // Frame byte count: saturates at COUNT_MAX, one more on the last beat
   localparam int COUNT_W = 13;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd4095;

   // Reply position counter
   localparam int POS_W = 12;
   localparam logic [POS_W-1:0] POS_MAX = 12'd4095;

   localparam logic [15:0] SUM_GOOD = 16'hFFFF;
   localparam logic [15:0] CSUM_RAISE = 16'h0800;
   localparam logic [3:0] IHL_MIN = 4'd5;
   localparam logic [3:0] IP_VERSION = 4'd4;
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;
   localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

   // Header offsets
   localparam logic [COUNT_W-1:0] OFS_VER_IHL = 13'd0;
   localparam logic [COUNT_W-1:0] OFS_LEN_HI = 13'd2;
   localparam logic [COUNT_W-1:0] OFS_LEN_LO = 13'd3;
   localparam logic [COUNT_W-1:0] OFS_PROTO = 13'd9;
   localparam logic [COUNT_W-1:0] OFS_SRC_FIRST = 13'd12;
   localparam logic [COUNT_W-1:0] OFS_SRC_LAST = 13'd15;
   localparam logic [POS_W-1:0] POS_SRC_FIRST = 12'd12;
   localparam logic [POS_W-1:0] POS_SRC_LAST = 12'd15;
   localparam logic [POS_W-1:0] POS_DST_FIRST = 12'd16;
   localparam logic [POS_W-1:0] POS_DST_LAST = 12'd19;
   localparam logic [COUNT_W-1:0] MIN_HEADER_BYTES = 13'd20;
   localparam logic [COUNT_W-1:0] MIN_ICMP_BYTES = 13'd8;

   // Drop reasons
   localparam logic [2:0] DROP_NONE = 3'd0;
   localparam logic [2:0] DROP_BAD_HEADER = 3'd1;
   localparam logic [2:0] DROP_BAD_CSUM = 3'd2;
   localparam logic [2:0] DROP_LEN_MISMATCH = 3'd3;
   localparam logic [2:0] DROP_NOT_ECHO = 3'd4;
   localparam logic [2:0] DROP_TOO_LONG = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       reply_last;
      logic       frame_ok;
      logic [2:0] drop_reason;
   } rsp_type;

   // Ones-complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[15:0] + {15'd0, sum[16]};
   endfunction

endpackage

[rtl/core/ipv4_icmp_echo_responder.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// IPv4 ICMP echo responder. Takes a frame one byte per beat on req_ and returns it on rsp_
// as an echo reply, eight bytes behind the input: source and destination addresses are
// swapped, the ICMP type becomes 0 and the ICMP checksum is raised by 0x0800 with
// end-around carry. Frames stream at one byte per cycle unless the output stalls; the
// nine-byte hold window sets the lag. After the beat with last_byte, input stalls while
// the held bytes drain, one per cycle unless the output stalls; the next frame can start
// on the cycle after the final reply byte is loaded. The final reply byte carries
// frame_ok and drop_reason (0 ok, 1 bad header, 2 bad checksum, 3 length mismatch,
// 4 not echo, 5 longer than MAX_FRAME).
// A dropped frame still comes out rewritten; the sink discards it on frame_ok low.
module ipv4_icmp_echo_responder #(
   parameter int MAX_FRAME = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ipv4_echo_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ipv4_echo_pkg::rsp_type rsp_data
);

   localparam int WinDepth = ipv4_echo_pkg::WIN;
   localparam logic [3:0] FillFull = 4'(WinDepth);
   localparam logic [ipv4_echo_pkg::COUNT_W-1:0] MaxFrameLimit =
      ipv4_echo_pkg::COUNT_W'(MAX_FRAME);

   // Hold window and frame state
   logic [7:0]  hold_ff [WinDepth];
   logic [7:0]  hold_in [WinDepth];
   logic [3:0]  fill_ff, fill_in;
   logic        flush_ff, flush_in;
   logic [ipv4_echo_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [ipv4_echo_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [3:0]  hwords_ff, hwords_in;
   logic        version_ok_ff, version_ok_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [15:0] header_sum_ff, header_sum_in;
   logic        proto_icmp_ff, proto_icmp_in;
   logic        type_echo_ff, type_echo_in;
   logic [31:0] src_addr_ff, src_addr_in;
   logic [7:0]  pending_hi_ff, pending_hi_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ipv4_echo_pkg::rsp_type rsp_ff, rsp_in;

   // Handshake
   logic out_ready;
   logic emit_ok;
   logic pop;
   logic final_pop;
   logic req_accept;

   // Datapath
   logic [3:0]  hw_cur;
   logic [12:0] hb_cur;
   logic [3:0]  fill_after;
   logic [12:0] hb_out;
   logic [11:0] hb_pos;
   logic [15:0] csum_hi;
   logic [15:0] csum_lo;
   logic [7:0]  reply_val;
   logic [2:0]  reason;
   logic [12:0] n_bytes;

   always_comb begin
      out_ready  = !rsp_valid_ff || !rsp_stall;
      emit_ok    = (fill_ff == FillFull) || (flush_ff && (fill_ff != 4'd0));
      pop        = emit_ok && out_ready;
      final_pop  = pop && flush_ff && (fill_ff == 4'd1);
      req_stall  = flush_ff || ((fill_ff == FillFull) && !pop);
      req_accept = req_valid && !req_stall;
   end

   // Rewrite the oldest held byte
   always_comb begin
      hb_out  = {7'd0, hwords_ff, 2'b00};
      hb_pos  = hb_out[11:0];
      csum_hi = ipv4_echo_pkg::oc_add({pending_hi_ff,
                                       (fill_ff >= 4'd2) ? hold_ff[1] : 8'd0},
                                      ipv4_echo_pkg::CSUM_RAISE);
      csum_lo = ipv4_echo_pkg::oc_add({pending_hi_ff, hold_ff[0]},
                                      ipv4_echo_pkg::CSUM_RAISE);
      reply_val = hold_ff[0];
      if ((pos_ff >= ipv4_echo_pkg::POS_SRC_FIRST) && (pos_ff <= ipv4_echo_pkg::POS_SRC_LAST)
          && (fill_ff >= 4'd5)) begin
         reply_val = hold_ff[4];
      end
      if ((pos_ff >= ipv4_echo_pkg::POS_DST_FIRST)
          && (pos_ff <= ipv4_echo_pkg::POS_DST_LAST)) begin
         unique case (pos_ff[1:0])
            2'd0:    reply_val = src_addr_ff[31:24];
            2'd1:    reply_val = src_addr_ff[23:16];
            2'd2:    reply_val = src_addr_ff[15:8];
            default: reply_val = src_addr_ff[7:0];
         endcase
      end
      if (hwords_ff >= ipv4_echo_pkg::IHL_MIN) begin
         if (pos_ff == hb_pos) begin
            reply_val = ipv4_echo_pkg::ICMP_ECHO_REPLY;
         end else if (pos_ff == hb_pos + 12'd2) begin
            reply_val = csum_hi[15:8];
         end else if (pos_ff == hb_pos + 12'd3) begin
            reply_val = csum_lo[7:0];
         end
      end
   end

   // Verdict from the completed frame state
   always_comb begin
      n_bytes = count_ff;
      if (n_bytes > MaxFrameLimit) begin
         reason = ipv4_echo_pkg::DROP_TOO_LONG;
      end else if ((n_bytes < ipv4_echo_pkg::MIN_HEADER_BYTES) || !version_ok_ff
                   || (hwords_ff < ipv4_echo_pkg::IHL_MIN) || (hb_out > n_bytes)) begin
         reason = ipv4_echo_pkg::DROP_BAD_HEADER;
      end else if (total_length_ff != {3'd0, n_bytes}) begin
         reason = ipv4_echo_pkg::DROP_LEN_MISMATCH;
      end else if (header_sum_ff != ipv4_echo_pkg::SUM_GOOD) begin
         reason = ipv4_echo_pkg::DROP_BAD_CSUM;
      end else if (!proto_icmp_ff || !type_echo_ff
                   || (n_bytes < hb_out + ipv4_echo_pkg::MIN_ICMP_BYTES)) begin
         reason = ipv4_echo_pkg::DROP_NOT_ECHO;
      end else begin
         reason = ipv4_echo_pkg::DROP_NONE;
      end
   end

   // Next state
   always_comb begin
      hold_in         = hold_ff;
      fill_in         = fill_ff;
      flush_in        = flush_ff;
      count_in        = count_ff;
      pos_in          = pos_ff;
      hwords_in       = hwords_ff;
      version_ok_in   = version_ok_ff;
      total_length_in = total_length_ff;
      header_sum_in   = header_sum_ff;
      proto_icmp_in   = proto_icmp_ff;
      type_echo_in    = type_echo_ff;
      src_addr_in     = src_addr_ff;
      pending_hi_in   = pending_hi_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;

      hw_cur = (count_ff == ipv4_echo_pkg::OFS_VER_IHL) ? req_data.data_byte[3:0] : hwords_ff;
      hb_cur = {7'd0, hw_cur, 2'b00};

      // Advance the hold window
      if (pop) begin
         for (int j = 0; j < WinDepth - 1; j++) begin
            hold_in[j] = hold_ff[j + 1];
         end
         pos_in = (pos_ff == ipv4_echo_pkg::POS_MAX) ? pos_ff : pos_ff + 12'd1;
      end
      fill_after = fill_ff - {3'd0, pop};
      for (int j = 0; j < WinDepth; j++) begin
         if (req_accept && (fill_after == 4'(j))) begin
            hold_in[j] = req_data.data_byte;
         end
      end
      fill_in = fill_after + {3'd0, req_accept};

      // Capture header fields and sum the header
      if (req_accept) begin
         if (count_ff == ipv4_echo_pkg::OFS_VER_IHL) begin
            version_ok_in = (req_data.data_byte[7:4] == ipv4_echo_pkg::IP_VERSION);
            hwords_in     = req_data.data_byte[3:0];
         end
         if (count_ff == ipv4_echo_pkg::OFS_LEN_HI) begin
            total_length_in[15:8] = req_data.data_byte;
         end
         if (count_ff == ipv4_echo_pkg::OFS_LEN_LO) begin
            total_length_in[7:0] = req_data.data_byte;
         end
         if (count_ff == ipv4_echo_pkg::OFS_PROTO) begin
            proto_icmp_in = (req_data.data_byte == ipv4_echo_pkg::PROTO_ICMP);
         end
         if ((count_ff >= ipv4_echo_pkg::OFS_SRC_FIRST)
             && (count_ff <= ipv4_echo_pkg::OFS_SRC_LAST)) begin
            src_addr_in = {src_addr_ff[23:0], req_data.data_byte};
         end
         if (count_ff < hb_cur) begin
            header_sum_in = ipv4_echo_pkg::oc_add(header_sum_ff,
               count_ff[0] ? {8'd0, req_data.data_byte} : {req_data.data_byte, 8'd0});
         end
         if (hw_cur >= ipv4_echo_pkg::IHL_MIN) begin
            if (count_ff == hb_cur) begin
               type_echo_in = (req_data.data_byte == ipv4_echo_pkg::ICMP_ECHO_REQ);
            end
            if (count_ff == hb_cur + 13'd2) begin
               pending_hi_in = req_data.data_byte;
            end
         end
         if (req_data.last_byte) begin
            count_in = count_ff + 13'd1;
            flush_in = 1'b1;
         end else if (count_ff < ipv4_echo_pkg::COUNT_MAX) begin
            count_in = count_ff + 13'd1;
         end
      end

      // Load the output register
      if (out_ready) begin
         rsp_valid_in = pop;
         if (pop) begin
            rsp_in.reply_byte  = reply_val;
            rsp_in.reply_last  = flush_ff && (fill_ff == 4'd1);
            rsp_in.frame_ok    = rsp_in.reply_last && (reason == ipv4_echo_pkg::DROP_NONE);
            rsp_in.drop_reason = rsp_in.reply_last ? reason : ipv4_echo_pkg::DROP_NONE;
         end
      end

      // Clear the frame after its last reply byte
      if (final_pop) begin
         for (int j = 0; j < WinDepth; j++) begin
            hold_in[j] = 8'd0;
         end
         fill_in         = 4'd0;
         flush_in        = 1'b0;
         count_in        = '0;
         pos_in          = '0;
         hwords_in       = 4'd0;
         version_ok_in   = 1'b0;
         total_length_in = 16'd0;
         header_sum_in   = 16'd0;
         proto_icmp_in   = 1'b0;
         type_echo_in    = 1'b0;
         src_addr_in     = 32'd0;
         pending_hi_in   = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         fill_ff         <= 4'd0;
         flush_ff        <= 1'b0;
         count_ff        <= '0;
         pos_ff          <= '0;
         hwords_ff       <= 4'd0;
         version_ok_ff   <= 1'b0;
         total_length_ff <= 16'd0;
         header_sum_ff   <= 16'd0;
         proto_icmp_ff   <= 1'b0;
         type_echo_ff    <= 1'b0;
         src_addr_ff     <= 32'd0;
         pending_hi_ff   <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         fill_ff         <= fill_in;
         flush_ff        <= flush_in;
         count_ff        <= count_in;
         pos_ff          <= pos_in;
         hwords_ff       <= hwords_in;
         version_ok_ff   <= version_ok_in;
         total_length_ff <= total_length_in;
         header_sum_ff   <= header_sum_in;
         proto_icmp_ff   <= proto_icmp_in;
         type_echo_ff    <= type_echo_in;
         src_addr_ff     <= src_addr_in;
         pending_hi_ff   <= pending_hi_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A full window must drain whenever a new beat enters
   `ASSERT_IMPL(a_full_pops, clock, reset, req_accept && (fill_ff == FillFull), pop,
      "beat accepted into full window without pop")
   // The final reply byte leaves the window empty and idle
   `ASSERT_NEXT(a_final_clears, clock, reset, final_pop, (fill_ff == 4'd0) && !flush_ff,
      "window not cleared after final byte")
   // A send verdict only rides on a last byte with no drop reason
   `ASSERT_IMPL(a_ok_on_last, clock, reset, rsp_valid_ff && rsp_ff.frame_ok,
      rsp_ff.reply_last && (rsp_ff.drop_reason == ipv4_echo_pkg::DROP_NONE),
      "frame_ok outside a clean last byte")

endmodule
